// ===== sv/dps_pkg.sv =====
// Shared types, constants and state codes for the dashed polyline stroker.
package dps_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int PAT_WIDTH        = 31;
    localparam int CFG_WIDTH        = 31;
    localparam int CFG_INDEX_WIDTH  = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JOIN_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DASH_ON_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_FIRST      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DASH_ON_SECOND = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_SECOND     = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH_DEF-1:0] point_x;
        logic signed [COORD_WIDTH_DEF-1:0] point_y;
        logic                              start_new;
    } in_beat_t;

    typedef struct packed {
        logic                              pen_down;
        logic signed [COORD_WIDTH_DEF-1:0] out_x;
        logic signed [COORD_WIDTH_DEF-1:0] out_y;
        logic                              last;
        logic                              truncated;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQRT,
        ST_FIRST,
        ST_ELEM,
        ST_DIV,
        ST_EMIT,
        ST_WAIT
    } dps_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_vertex;
        logic start_sqrt;
        logic sqrt_step;
        logic elem_setup;
        logic start_div;
        logic div_step;
        logic emit_first;
        logic emit_elem;
        logic out_taken;
    } dps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic restart;
        logic no_join;
        logic solid;
        logic sqrt_done;
        logic len_zero;
        logic on_phase;
        logic elem_final;
        logic div_done;
        logic out_valid;
        logic run_over;
    } dps_stat_t;

endpackage

// ===== sv/dps_datapath.sv =====
// Datapath: vertex state, square root, divider and command formation.
module dps_datapath #(
    parameter int MAX_SEGMENTS = dps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dps_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  dps_pkg::in_beat_t                 in_beat,
    input  dps_pkg::dps_cmd_t                 cmd,
    output dps_pkg::dps_stat_t                stat,
    output dps_pkg::out_beat_t                out_beat
);
    import dps_pkg::*;

    localparam int CW  = COORD_WIDTH_DEF;
    localparam int DW  = CW + 1;           // coordinate difference width
    localparam int SW  = 2 * DW;           // square sum width
    localparam int LW  = DW;               // length width
    localparam int NW  = LW + CW + 1;      // numerator width of along()
    localparam int QW  = DW;               // offset width
    localparam int DTW = LW + 2;           // distance width
    localparam int CNW = $clog2(MAX_SEGMENTS + 1);
    localparam int SCW = $clog2(LW + 1);
    localparam int DCW = $clog2(NW + 1);

    // Configuration registers.
    logic               join_en_reg;
    logic [PAT_WIDTH-1:0] pat_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_en_reg <= 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_JOIN_ENABLE:    join_en_reg <= cfg_data[0];
                CFG_DASH_ON_FIRST:  pat_reg[0]  <= cfg_data;
                CFG_GAP_FIRST:      pat_reg[1]  <= cfg_data;
                CFG_DASH_ON_SECOND: pat_reg[2]  <= cfg_data;
                CFG_GAP_SECOND:     pat_reg[3]  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Vertex and pattern state.
    logic                 have_prev_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] px_reg, py_reg, nx_reg, ny_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [1:0]           phase_reg;
    logic [PAT_WIDTH:0]   pos_reg;
    logic [CNW-1:0]       cnt_reg;
    logic                 cut_reg;

    logic signed [DW-1:0] dx_w, dy_w;
    logic [DW-1:0]        ax_w, ay_w;
    assign dx_w = DW'(in_beat.point_x) - DW'(prev_x_reg);
    assign dy_w = DW'(in_beat.point_y) - DW'(prev_y_reg);
    assign ax_w = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ay_w = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    // Square root: the x square is registered first, then the sum of squares, then one bit a cycle.
    logic [SW-1:0]  sq_x_reg, sq_sum_reg;
    logic [LW-1:0]  len_reg;
    logic [SW-1:0]  sq_rem_reg;
    logic [SCW-1:0] sq_bit_reg;
    logic           sq_sum_ok_reg;
    logic           sq_busy_reg;
    logic [SW-1:0]  sq_trial_w;
    logic [SW-1:0]  sq_left_w;

    // Restoring square root with a remainder, two input bits for one result bit a step.
    assign sq_left_w  = {sq_rem_reg[SW-3:0],
                         sq_sum_reg[SW-1 - 2*(LW-1-32'(sq_bit_reg)) -: 2]};
    assign sq_trial_w = {len_reg, 2'b01};

    // Element walk.
    logic [DTW-1:0] base_reg, tgt_reg, d_reg;
    logic           fin_reg;
    logic [DTW-1:0] rem_w, tgt_w, d_w;
    assign rem_w = (PAT_WIDTH+1)'(pat_reg[phase_reg]) > pos_reg ?
                   DTW'((PAT_WIDTH+1)'(pat_reg[phase_reg]) - pos_reg) : '0;
    assign tgt_w = base_reg + rem_w;
    assign d_w   = tgt_w > DTW'(len_reg) ? DTW'(len_reg) : tgt_w;

    // Shared divider: floor(d*|delta|/len) for x then y, one bit a cycle.
    logic [NW-1:0]  dv_num_reg;
    logic [LW:0]    dv_rem_reg;
    logic [QW-1:0]  dv_q_reg;
    logic [DCW-1:0] dv_cnt_reg;
    logic           dv_axis_reg;
    logic           dv_busy_reg;
    logic           dv_mul_reg;
    logic [QW-1:0]  offx_reg;
    logic [LW:0]    dv_shift_w;
    logic [DW-1:0]  dv_mag_w;
    assign dv_shift_w = {dv_rem_reg[LW-1:0], dv_num_reg[NW-1]};
    assign dv_mag_w   = dv_axis_reg ? ay_w : ax_w;

    // Output register.
    out_beat_t out_reg;
    logic      ov_reg;
    logic signed [CW-1:0] ex_w, ey_w;
    logic      final_w, trunc_w;
    assign ex_w = dx_reg[DW-1] ? CW'(px_reg - CW'(offx_reg)) : CW'(px_reg + CW'(offx_reg));
    assign ey_w = dy_reg[DW-1] ? CW'(py_reg - CW'(dv_q_reg)) : CW'(py_reg + CW'(dv_q_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            phase_reg     <= '0;
            pos_reg       <= '0;
            ov_reg        <= 1'b0;
            sq_busy_reg   <= 1'b0;
            dv_busy_reg   <= 1'b0;
            cnt_reg       <= '0;
            cut_reg       <= 1'b0;
        end
        else
        begin
            // A new command beat takes the output register as the old one leaves.
            if (cmd.emit_first || cmd.emit_elem)
            begin
                ov_reg <= 1'b1;
            end
            else if (cmd.out_taken)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.load_vertex)
            begin
                px_reg        <= prev_x_reg;
                py_reg        <= prev_y_reg;
                nx_reg        <= in_beat.point_x;
                ny_reg        <= in_beat.point_y;
                dx_reg        <= dx_w;
                dy_reg        <= dy_w;
                prev_x_reg    <= in_beat.point_x;
                prev_y_reg    <= in_beat.point_y;
                have_prev_reg <= 1'b1;
                cnt_reg       <= '0;
                cut_reg       <= 1'b0;
                base_reg      <= '0;
                sq_sum_ok_reg <= 1'b0;
                if (in_beat.start_new || !have_prev_reg)
                begin
                    phase_reg <= '0;
                    pos_reg   <= '0;
                end
            end
            if (cmd.start_sqrt)
            begin
                sq_x_reg      <= SW'(ax_w) * SW'(ax_w);
                sq_sum_ok_reg <= 1'b0;
                sq_busy_reg   <= 1'b1;
                sq_rem_reg    <= '0;
                len_reg       <= '0;
                sq_bit_reg    <= SCW'(LW - 1);
            end
            if (cmd.sqrt_step)
            begin
                if (!sq_sum_ok_reg)
                begin
                    sq_sum_reg    <= sq_x_reg + SW'(ay_w) * SW'(ay_w);
                    sq_sum_ok_reg <= 1'b1;
                end
                else
                begin
                    if (sq_left_w >= sq_trial_w)
                    begin
                        sq_rem_reg <= sq_left_w - sq_trial_w;
                        len_reg    <= {len_reg[LW-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_left_w;
                        len_reg    <= {len_reg[LW-2:0], 1'b0};
                    end
                    if (sq_bit_reg == '0)
                    begin
                        sq_busy_reg <= 1'b0;
                    end
                    else
                    begin
                        sq_bit_reg <= sq_bit_reg - SCW'(1);
                    end
                end
            end
            if (cmd.elem_setup)
            begin
                tgt_reg <= tgt_w;
                d_reg   <= d_w;
                fin_reg <= d_w >= DTW'(len_reg);
            end
            if (cmd.start_div)
            begin
                dv_axis_reg <= 1'b0;
                dv_mul_reg  <= 1'b1;
                dv_busy_reg <= 1'b1;
            end
            if (cmd.div_step)
            begin
                if (dv_mul_reg)
                begin
                    dv_num_reg <= NW'(d_reg) * NW'(dv_mag_w);
                    dv_rem_reg <= '0;
                    dv_q_reg   <= '0;
                    dv_cnt_reg <= DCW'(NW);
                    dv_mul_reg <= 1'b0;
                end
                else if (dv_cnt_reg != '0)
                begin
                    dv_num_reg <= {dv_num_reg[NW-2:0], 1'b0};
                    if (dv_shift_w >= (LW+1)'(len_reg))
                    begin
                        dv_rem_reg <= dv_shift_w - (LW+1)'(len_reg);
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg <= dv_shift_w;
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b0};
                    end
                    dv_cnt_reg <= dv_cnt_reg - DCW'(1);
                end
                else if (!dv_axis_reg)
                begin
                    offx_reg    <= dv_q_reg;
                    dv_axis_reg <= 1'b1;
                    dv_mul_reg  <= 1'b1;
                end
                else
                begin
                    dv_busy_reg <= 1'b0;
                end
            end
            if (cmd.emit_first)
            begin
                cnt_reg          <= cnt_reg + CNW'(1);
                out_reg.pen_down <= 1'b0;
                out_reg.last     <= len_reg == '0 || trunc_w;
                out_reg.truncated <= trunc_w;
                out_reg.out_x    <= trunc_w ? nx_reg : px_reg;
                out_reg.out_y    <= trunc_w ? ny_reg : py_reg;
                if (trunc_w)
                begin
                    cut_reg <= 1'b1;
                end
            end
            if (cmd.emit_elem)
            begin
                cnt_reg           <= cnt_reg + CNW'(1);
                out_reg.pen_down  <= trunc_w ? 1'b0 : !phase_reg[0];
                out_reg.last      <= fin_reg || trunc_w;
                out_reg.truncated <= trunc_w;
                out_reg.out_x     <= (fin_reg || trunc_w) ? nx_reg : ex_w;
                out_reg.out_y     <= (fin_reg || trunc_w) ? ny_reg : ey_w;
                if (trunc_w)
                begin
                    cut_reg   <= 1'b1;
                    phase_reg <= '0;
                    pos_reg   <= '0;
                end
                else if (fin_reg)
                begin
                    pos_reg <= (PAT_WIDTH+1)'(DTW'(pos_reg) + d_reg - base_reg);
                end
                else
                begin
                    base_reg  <= tgt_reg;
                    phase_reg <= phase_reg + 2'd1;
                    pos_reg   <= '0;
                end
            end
            if (cmd.emit_first && trunc_w)
            begin
                phase_reg <= '0;
                pos_reg   <= '0;
            end
        end
    end

    // A non-final command at the last slot becomes the truncating jump.
    assign final_w = cmd.emit_first ? (len_reg == '0) : fin_reg;
    assign trunc_w = !final_w && (cnt_reg >= CNW'(MAX_SEGMENTS - 1));

    assign stat.restart    = in_beat.start_new || !have_prev_reg;
    assign stat.no_join    = !join_en_reg;
    assign stat.solid      = pat_reg[0] == '0;
    assign stat.sqrt_done  = !sq_busy_reg;
    assign stat.len_zero   = len_reg == '0;
    assign stat.on_phase   = !phase_reg[0];
    assign stat.elem_final = fin_reg;
    assign stat.div_done   = !dv_busy_reg;
    assign stat.out_valid  = ov_reg;
    assign stat.run_over   = cut_reg;

    assign out_beat = out_reg;
endmodule

// ===== sv/dps_control.sv =====
// Controller state machine that sequences one vertex through the datapath.
module dps_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  dps_pkg::dps_stat_t stat,
    output dps_pkg::dps_cmd_t  cmd
);
    import dps_pkg::*;

    dps_state_t state_reg, state_next;
    logic       solid_reg, solid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            solid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            solid_reg <= solid_next;
        end
    end

    logic taken;
    assign taken     = stat.out_valid && out_ready;
    assign out_valid = stat.out_valid;
    assign in_ready  = state_reg == ST_IDLE;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        solid_next = solid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.restart || stat.no_join)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        solid_next = stat.solid;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (!stat.out_valid || taken)
                begin
                    if (solid_reg)
                    begin
                        state_next = ST_WAIT;
                    end
                    else if (stat.on_phase && stat.len_zero)
                    begin
                        state_next = ST_WAIT;
                    end
                    else if (stat.len_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ELEM;
                    end
                end
            end
            ST_ELEM:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done && (!stat.out_valid || taken))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.run_over || stat.elem_final)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_ELEM;
                end
            end
            ST_WAIT:
            begin
                if (!stat.out_valid || taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd = '0;
        cmd.out_taken = taken;
        unique case (state_reg)
            ST_IDLE:  cmd.load_vertex = in_valid;
            ST_SETUP: cmd.start_sqrt = 1'b1;
            ST_SQRT:  cmd.sqrt_step = !stat.sqrt_done;
            ST_FIRST:
            begin
                if (!stat.out_valid || taken)
                begin
                    cmd.emit_first = solid_reg || stat.on_phase;
                end
            end
            ST_ELEM:
            begin
                cmd.elem_setup = 1'b1;
                cmd.start_div  = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = !stat.div_done;
                cmd.emit_elem = stat.div_done && (!stat.out_valid || taken);
            end
            ST_EMIT:  ;
            ST_WAIT:  ;
            default:  ;
        endcase
    end
endmodule

// ===== sv/dps_solid.sv =====
// Solid-line step: turns the second command of a solid segment into a draw.
module dps_solid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               solid_mode,
    input  logic               first_taken,
    input  logic signed [dps_pkg::COORD_WIDTH_DEF-1:0] vx,
    input  logic signed [dps_pkg::COORD_WIDTH_DEF-1:0] vy,
    input  dps_pkg::out_beat_t dp_beat,
    input  logic               dp_valid,
    input  logic               out_ready,
    output logic               out_valid,
    output dps_pkg::out_beat_t out_beat,
    output logic               busy
);
    import dps_pkg::*;

    // After the move of a solid segment is taken, a draw to the vertex follows.
    logic pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (first_taken && solid_mode)
        begin
            pend_reg <= 1'b1;
        end
        else if (pend_reg && out_ready)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_beat = dp_beat;
        if (pend_reg)
        begin
            out_beat.pen_down  = 1'b1;
            out_beat.out_x     = vx;
            out_beat.out_y     = vy;
            out_beat.last      = 1'b1;
            out_beat.truncated = 1'b0;
        end
        else if (solid_mode)
        begin
            out_beat.last = 1'b0;
        end
    end

    assign out_valid = pend_reg || dp_valid;
    assign busy      = pend_reg;
endmodule

// ===== sv/dashed_polyline_stroker.sv =====
// Top level of the dashed polyline stroker.
// A vertex beat that joins to the previous one forms its squared length (x square, then sum)
// and its square root, one result bit a cycle (33 bits at 32-bit coordinates), before its
// first pen command. Each dash command after that waits on the shared bit-serial divider,
// which runs twice (x then y), so dash commands leave one at a time; the draw of a solid
// segment follows in the cycle after its move is taken. A new vertex is accepted only once
// every command of the previous one has been taken; a vertex that draws nothing (restart or
// joining off) leaves the block idle and ready for the next vertex.
module dashed_polyline_stroker #(
    parameter int MAX_SEGMENTS = dps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dps_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dps_pkg::in_beat_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output dps_pkg::out_beat_t                 out_data
);
    import dps_pkg::*;

    dps_cmd_t  cmd;
    dps_stat_t stat, stat_c;
    out_beat_t dp_beat;
    logic      ctl_in_ready, ctl_out_valid, solid_busy, solid_mode_reg;
    logic signed [COORD_WIDTH_DEF-1:0] vx_reg, vy_reg;

    dps_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_beat(in_data), .cmd, .stat, .out_beat(dp_beat)
    );

    // The solid draw keeps the controller waiting until it is taken.
    always_comb
    begin
        stat_c = stat;
        stat_c.out_valid = stat.out_valid || solid_busy;
    end

    dps_control u_ctl (
        .clk, .rst_n, .in_valid(in_valid && !solid_busy), .in_ready(ctl_in_ready),
        .out_ready(out_ready && !solid_busy), .out_valid(ctl_out_valid),
        .stat(stat_c), .cmd
    );

    // Segment mode and vertex of the beat being worked on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solid_mode_reg <= 1'b0;
            vx_reg         <= '0;
            vy_reg         <= '0;
        end
        else if (cmd.load_vertex)
        begin
            solid_mode_reg <= stat.solid;
            vx_reg         <= in_data.point_x;
            vy_reg         <= in_data.point_y;
        end
    end

    dps_solid u_solid (
        .clk, .rst_n, .solid_mode(solid_mode_reg),
        .first_taken(stat.out_valid && out_ready && !solid_busy),
        .vx(vx_reg), .vy(vy_reg),
        .dp_beat, .dp_valid(stat.out_valid && !solid_busy), .out_ready,
        .out_valid, .out_beat(out_data), .busy(solid_busy)
    );

    assign in_ready = ctl_in_ready && !solid_busy;
endmodule

// ===== sv/dps_checker.sv =====
// Port-level checker for the dashed polyline stroker, bound to the top level.
module dps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dps_pkg::out_beat_t out_data
);
    // An output beat waiting for the sink holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // No vertex is taken while a command is still offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("vertex accepted during command run");

    // A truncating command always ends the vertex as a move.
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.truncated |-> out_data.last && !out_data.pen_down)
        else $error("truncated command malformed");
endmodule

bind dashed_polyline_stroker dps_checker u_dps_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data(out_data)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dashed polyline stroker: directed and random vertex streams.
module testbench;
    import dps_pkg::*;

    localparam int MAX_CMDS = MAX_SEGMENTS_DEF;
    localparam int IDLE_WAIT = 100;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    in_beat_t                   in_data;
    logic                       out_valid;
    logic                       out_ready;
    out_beat_t                  out_data;

    dashed_polyline_stroker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Mirror of the stroker state and registers.
    bit          join_en;
    logic [30:0] pat_len [4];
    bit          have_prev;
    longint      prev_x;
    longint      prev_y;
    logic [1:0]  dash_ph;
    logic [31:0] elem_pos;

    // Pen commands still owed by the block, oldest first.
    out_beat_t   pending_cmds[$];
    int          cmd_count;
    bit          cmd_cut;

    int          errors;
    int          vertices_sent;
    int          cmds_checked;
    int          cuts_seen;
    int          burst_left;
    int          stall_pct;

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit, far above the slowest legal run.
    initial
    begin
        #(12 * 30000000);
        $display("status: fail");
        $finish;
    end

    function automatic in_beat_t vertex(longint x, longint y, bit s);
        in_beat_t b;
        b.point_x   = x[31:0];
        b.point_y   = y[31:0];
        b.start_new = s;
        return b;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 52; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // Point at distance d along a segment axis of length seg_len.
    function automatic longint point_along(longint base, longint delta,
                                           logic [63:0] d, logic [63:0] seg_len);
        logic [127:0] mag;
        logic [127:0] off;
        mag = (delta < 0) ? 128'(-delta) : 128'(delta);
        off = (128'(d) * mag) / 128'(seg_len);
        return (delta < 0) ? base - longint'(off[63:0]) : base + longint'(off[63:0]);
    endfunction

    // Queue one pen command, applying the per-vertex command limit.
    task automatic queue_cmd(bit pen, longint x, longint y, bit fin, longint vx, longint vy);
        out_beat_t e;
        if (cmd_cut)
            return;
        e.truncated = 1'b0;
        e.last      = fin;
        e.pen_down  = pen;
        e.out_x     = x[31:0];
        e.out_y     = y[31:0];
        if (!fin && cmd_count >= MAX_CMDS - 1)
        begin
            e.pen_down  = 1'b0;
            e.out_x     = vx[31:0];
            e.out_y     = vy[31:0];
            e.last      = 1'b1;
            e.truncated = 1'b1;
            cmd_cut     = 1'b1;
        end
        pending_cmds.push_back(e);
        cmd_count++;
    endtask

    // Work out the pen commands that one accepted vertex causes.
    task automatic stroke_vertex(in_beat_t b);
        longint       nx;
        longint       ny;
        longint       px;
        longint       py;
        longint       dx;
        longint       dy;
        longint       x;
        longint       y;
        logic [127:0] ax;
        logic [127:0] ay;
        logic [63:0]  seg_len;
        logic [63:0]  base_d;
        logic [63:0]  remain;
        logic [63:0]  target;
        logic [63:0]  reach;
        logic [1:0]   ph;
        logic [31:0]  pos;
        bit           fin;
        nx = longint'(b.point_x);
        ny = longint'(b.point_y);
        px = prev_x;
        py = prev_y;
        cmd_count = 0;
        cmd_cut   = 1'b0;
        if (b.start_new || !have_prev)
        begin
            have_prev = 1'b1;
            prev_x    = nx;
            prev_y    = ny;
            dash_ph   = '0;
            elem_pos  = '0;
            return;
        end
        prev_x = nx;
        prev_y = ny;
        if (!join_en)
            return;
        // Solid line: move to the old vertex, draw to the new one.
        if (pat_len[0] == 0)
        begin
            queue_cmd(1'b0, px, py, 1'b0, nx, ny);
            queue_cmd(1'b1, nx, ny, 1'b1, nx, ny);
            return;
        end
        dx = nx - px;
        dy = ny - py;
        ax = (dx < 0) ? 128'(-dx) : 128'(dx);
        ay = (dy < 0) ? 128'(-dy) : 128'(dy);
        seg_len = isqrt(ax * ax + ay * ay);
        ph  = dash_ph;
        pos = elem_pos;
        if (!ph[0])
            queue_cmd(1'b0, px, py, seg_len == 0, nx, ny);
        // Walk the pattern elements until the vertex is reached.
        base_d = '0;
        while (seg_len > 0 && !cmd_cut)
        begin
            remain = (pat_len[ph] > pos) ? 64'(pat_len[ph] - pos) : 64'd0;
            target = base_d + remain;
            reach  = (target > seg_len) ? seg_len : target;
            fin    = (reach >= seg_len);
            x = fin ? nx : point_along(px, dx, reach, seg_len);
            y = fin ? ny : point_along(py, dy, reach, seg_len);
            queue_cmd(!ph[0], x, y, fin, nx, ny);
            if (fin)
            begin
                pos = pos + 32'(reach - base_d);
                break;
            end
            base_d = target;
            ph     = ph + 2'd1;
            pos    = '0;
        end
        if (cmd_cut)
        begin
            dash_ph  = '0;
            elem_pos = '0;
        end
        else
        begin
            dash_ph  = ph;
            elem_pos = pos;
        end
    endtask

    // Send one vertex beat, with bursts and random gaps on the sender side.
    task automatic send_vertex(in_beat_t b);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid = 1'b1;
        in_data  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stroke_vertex(b);
        vertices_sent++;
        @(negedge clk);
    endtask

    // Let the block drain before touching its registers.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [30:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_JOIN_ENABLE)
            join_en = value[0];
        else
            pat_len[2'(idx - CFG_DASH_ON_FIRST)] = value;
    endtask

    task automatic write_pattern(logic [30:0] on1, logic [30:0] off1,
                                 logic [30:0] on2, logic [30:0] off2);
        write_reg(CFG_DASH_ON_FIRST, on1);
        write_reg(CFG_GAP_FIRST, off1);
        write_reg(CFG_DASH_ON_SECOND, on2);
        write_reg(CFG_GAP_SECOND, off2);
    endtask

    // Reset defaults: solid lines, field extremes, restarts.
    task automatic test_solid_lines();
        send_vertex(vertex(0, 0, 1'b0));
        send_vertex(vertex(32'h7fffffff, 32'h7fffffff, 1'b0));
        send_vertex(vertex(-64'sh80000000, -64'sh80000000, 1'b0));
        send_vertex(vertex(-64'sh80000000, 32'h7fffffff, 1'b1));
        send_vertex(vertex(32'h7fffffff, -64'sh80000000, 1'b0));
        send_vertex(vertex(5 << 16, -7 << 16, 1'b0));
    endtask

    // Joining off stores vertices and draws nothing.
    task automatic test_join_disabled();
        wait_idle();
        write_reg(CFG_JOIN_ENABLE, 31'd0);
        send_vertex(vertex(1 << 16, 1 << 16, 1'b0));
        send_vertex(vertex(9 << 16, 3 << 16, 1'b0));
        wait_idle();
        write_reg(CFG_JOIN_ENABLE, 31'd1);
        send_vertex(vertex(-4 << 16, 2 << 16, 1'b0));
    endtask

    // Dash pattern corners: zero-length segments in both phases, zero-length
    // elements, a pattern shrunk mid-line, the command limit, maximum lengths.
    task automatic test_dash_corners();
        wait_idle();
        write_pattern(31'(10 << 16), 31'(10 << 16), 31'(10 << 16), 31'(10 << 16));
        send_vertex(vertex(0, 0, 1'b1));
        send_vertex(vertex(15 << 16, 0, 1'b0));
        send_vertex(vertex(15 << 16, 0, 1'b0));
        send_vertex(vertex(25 << 16, 0, 1'b0));
        send_vertex(vertex(25 << 16, 0, 1'b0));
        wait_idle();
        write_pattern(31'(100 << 16), 31'(6 << 16), 31'd0, 31'd0);
        send_vertex(vertex(0, 0, 1'b1));
        send_vertex(vertex(18 << 16, 24 << 16, 1'b0));
        wait_idle();
        write_reg(CFG_DASH_ON_FIRST, 31'(4 << 16));
        send_vertex(vertex(-30 << 16, 10 << 16, 1'b0));
        wait_idle();
        write_pattern(31'd1, 31'd1, 31'd1, 31'd1);
        send_vertex(vertex(0, 0, 1'b1));
        send_vertex(vertex(100 << 16, -3 << 16, 1'b0));
        send_vertex(vertex(90 << 16, 40 << 16, 1'b0));
        wait_idle();
        write_pattern(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        send_vertex(vertex(-64'sh80000000, -64'sh80000000, 1'b1));
        send_vertex(vertex(32'h7fffffff, 32'h7fffffff, 1'b0));
        send_vertex(vertex(-64'sh80000000, 32'h7fffffff, 1'b0));
    endtask

    // Random phases: each picks a pattern scaled to its coordinate spread.
    task automatic test_random_paths();
        longint     cx;
        longint     cy;
        longint     spread;
        int         sh;
        in_beat_t   b;
        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            sh = $urandom_range(12, 31);
            spread = longint'(1) << sh;
            write_reg(CFG_JOIN_ENABLE, ($urandom_range(0, 7) != 0) ? 31'd1 : 31'd0);
            if ($urandom_range(0, 5) == 0)
                write_pattern(31'd0, 31'($urandom), 31'($urandom), 31'($urandom));
            else
                write_pattern(31'($urandom_range(1, 31'(spread - 1))),
                              31'($urandom_range(0, 31'(spread - 1))),
                              ($urandom_range(0, 4) == 0) ? 31'd0 :
                                  31'($urandom_range(0, 31'(spread - 1))),
                              31'($urandom_range(0, 31'(spread - 1))));
            cx = longint'(signed'(32'($urandom)));
            cy = longint'(signed'(32'($urandom)));
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    b = vertex($urandom, $urandom, 1'($urandom_range(0, 1)));
                else
                    b = vertex(cx + longint'($urandom_range(0, 31'(spread - 1))),
                               cy + longint'($urandom_range(0, 31'(spread - 1))),
                               $urandom_range(0, 9) == 0);
                send_vertex(b);
            end
        end
    endtask

    // Receiver stalls: each falling edge may redraw the stall rate, with a chance of 1 in 400.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 399) == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each pen command beat against the oldest expectation.
    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected pen command x=%h y=%h", out_data.out_x, out_data.out_y);
                errors++;
            end
            else
            begin
                e = pending_cmds.pop_front();
                cmds_checked++;
                if (out_data.truncated)
                    cuts_seen++;
                if (out_data.pen_down !== e.pen_down)
                begin
                    $error("pen_down expected %0d got %0d", e.pen_down, out_data.pen_down);
                    errors++;
                end
                if (out_data.out_x !== e.out_x)
                begin
                    $error("out_x expected %h got %h", e.out_x, out_data.out_x);
                    errors++;
                end
                if (out_data.out_y !== e.out_y)
                begin
                    $error("out_y expected %h got %h", e.out_y, out_data.out_y);
                    errors++;
                end
                if (out_data.last !== e.last)
                begin
                    $error("last expected %0d got %0d", e.last, out_data.last);
                    errors++;
                end
                if (out_data.truncated !== e.truncated)
                begin
                    $error("truncated expected %0d got %0d", e.truncated, out_data.truncated);
                    errors++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        stall_pct  = 0;
        burst_left = 0;
        errors     = 0;
        join_en    = 1'b1;
        for (int i = 0; i < 4; i++)
            pat_len[i] = '0;
        have_prev  = 1'b0;
        prev_x     = 0;
        prev_y     = 0;
        dash_ph    = '0;
        elem_pos   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_solid_lines();
        test_join_disabled();
        test_dash_corners();
        test_random_paths();

        wait_idle();
        if (pending_cmds.size() != 0)
        begin
            $error("%0d pen commands never arrived", pending_cmds.size());
            errors++;
        end
        $display("Covered %0d vertices and %0d pen commands, %0d of them cut short.",
                 vertices_sent, cmds_checked, cuts_seen);
        $display("Patterns ranged from solid through one-unit dashes to maximum lengths.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dps_pkg.sv
sv/dps_datapath.sv
sv/dps_control.sv
sv/dps_solid.sv
sv/dashed_polyline_stroker.sv
sv/dps_checker.sv
tb/sv/testbench.sv
